// File: rtl/core/crash_record_validator_defines.svh
// ----------------------------------------------------------------------------
// Crash record validator assertion macros
// Concurrent assertion wrappers, compiled away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CRASH_RECORD_VALIDATOR_DEFINES_SVH
`define CRASH_RECORD_VALIDATOR_DEFINES_SVH

`ifndef SYNTH

// Checked only while out of reset.
`define CRV_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CRV_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CRV_ASSERT(name, prop, msg)
`define CRV_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// File: rtl/core/crv_pkg.sv
// ----------------------------------------------------------------------------
// Crash record validator package
// Item types, record layout constants, register indexes and the CRC32C step.
// ----------------------------------------------------------------------------
package crv_pkg;

	localparam int unsigned V1_HEADER_BYTES = 40;
	localparam int unsigned V2_HEADER_BYTES = 44;
	localparam int unsigned TRAIL_BYTES     = 4;

	// Byte offsets inside a record.
	localparam int unsigned POS_CRC_START = 4;
	localparam int unsigned POS_VERSION   = 6;
	localparam int unsigned POS_PAD       = 7;
	localparam int unsigned POS_TIME      = 8;
	localparam int unsigned POS_TIME_END  = 16;
	localparam int unsigned POS_KIND      = 24;
	localparam int unsigned POS_KIND_END  = 28;
	localparam int unsigned POS_LEN       = 28;
	localparam int unsigned POS_LEN_END   = 44;

	// "KQCRSH", first byte in the lowest lane.
	localparam logic [5:0][7:0] MAGIC = 48'h4853_5243_514B;
	localparam logic [7:0] VER_ONE = 8'h31;
	localparam logic [7:0] VER_TWO = 8'h32;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [31:0] KIND_MIN = 32'd1;
	localparam logic [31:0] KIND_MAX = 32'd4;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIELD_LIMIT   = 2'd0,
		REG_VERSION_LIMIT = 2'd1,
		REG_ARCH_LIMIT    = 2'd2,
		REG_RECORD_LIMIT  = 2'd3
	} cfg_reg_e_t;

	localparam logic [15:0] FIELD_LIMIT_RST   = 16'd1024;
	localparam logic [7:0]  VERSION_LIMIT_RST = 8'd64;
	localparam logic [7:0]  ARCH_LIMIT_RST    = 8'd32;
	localparam logic [15:0] RECORD_LIMIT_RST  = 16'd4096;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] declared_size;
	} rec_item_t;

	typedef struct packed {
		logic        valid_res;
		logic [62:0] timestamp;
	} res_item_t;

	// One reflected CRC32C byte step.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/core/crash_record_validator.sv
// ----------------------------------------------------------------------------
// Crash record validator
// Streams a stored crash record byte by byte, checks header, bounds, total
// length, timestamp and trailing CRC32C, and reports one result per record.
// ----------------------------------------------------------------------------
//  Channel  Signals                         Direction  Moves
//  rec      rec_valid, rec_ready, rec_item  in         one record byte per item
//  res      res_valid, res_ready, res_item  out        one result per record
//  cfg      cfg_we, cfg_index, cfg_data     in         limit register writes
//
// One record byte is taken every cycle while rec_ready is high; the CRC32C
// byte step and field capture sit between the input register and the record
// state. After its last byte is accepted, a result passes the input register,
// the snapshot of the record, the partial length sums and the result register.
// rec_ready drops only while a last byte waits for a full result path.
// Reset is asynchronous; limits return to their defaults, no clearing pass.
// ----------------------------------------------------------------------------
`include "crash_record_validator_defines.svh"

module crash_record_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rec_valid,
	output logic                                rec_ready,
	input  crv_pkg::rec_item_t                  rec_item,
	output logic                                res_valid,
	input  logic                                res_ready,
	output crv_pkg::res_item_t                  res_item,
	input  logic                                cfg_we,
	input  logic [crv_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [crv_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import crv_pkg::*;

	// Limit registers.
	logic [15:0] field_limit_q;
	logic [7:0]  version_limit_q;
	logic [7:0]  arch_limit_q;
	logic [15:0] record_limit_q;

	// Record state.
	logic [15:0]          cnt_q;
	logic [31:0]          crc_q;
	logic [31:0]          win_q;
	logic                 hdr_ok_q;
	logic                 fmt_two_q;
	logic [7:0][7:0]      time_q;
	logic [3:0][7:0]      kind_q;
	logic [3:0][3:0][7:0] len_q;

	logic [15:0]          cnt_d;
	logic [31:0]          crc_d;
	logic [31:0]          win_d;
	logic                 hdr_ok_d;
	logic                 fmt_two_d;
	logic [7:0][7:0]      time_d;
	logic [3:0][7:0]      kind_d;
	logic [3:0][3:0][7:0] len_d;
	logic [5:0]           len_off;

	// Input stage.
	logic      vld_s1;
	rec_item_t item_s1;

	// Snapshot of a finished record.
	logic                 vld_s2;
	logic [16:0]          n_s2;
	logic [15:0]          decl_s2;
	logic                 hdr_ok_s2;
	logic                 fmt_two_s2;
	logic [63:0]          time_s2;
	logic [31:0]          kind_s2;
	logic [3:0][31:0]     len_s2;
	logic [31:0]          crc_s2;
	logic [31:0]          win_s2;

	// Check flags and partial sums.
	logic        vld_s3;
	logic        chk_s3;
	logic [32:0] sum_a_s3;
	logic [32:0] sum_b_s3;
	logic [6:0]  hdr4_s3;
	logic [15:0] decl_s3;
	logic [62:0] time_s3;

	logic      res_valid_q;
	res_item_t res_item_q;

	logic        out_free;
	logic        s3_free;
	logic        s2_free;
	logic        s1_adv;

	logic [31:0] arch_len;
	logic [6:0]  hdr4;
	logic        chk;
	logic [33:0] total;
	logic        rec_ok;

	// ------------------------------------------------------------------------
	// Flow control: only last bytes travel past the input stage.
	// ------------------------------------------------------------------------
	assign out_free  = !res_valid_q || res_ready;
	assign s3_free   = !vld_s3 || out_free;
	assign s2_free   = !vld_s2 || s3_free;
	assign s1_adv    = vld_s1 && (!item_s1.last_byte || s2_free);
	assign rec_ready = !vld_s1 || s1_adv;

	// ------------------------------------------------------------------------
	// Per-byte update of the record state.
	// ------------------------------------------------------------------------
	assign len_off = cnt_q[5:0] - 6'(POS_LEN);

	always_comb begin
		hdr_ok_d  = hdr_ok_q;
		fmt_two_d = fmt_two_q;
		time_d    = time_q;
		kind_d    = kind_q;
		len_d     = len_q;

		if (cnt_q < 16'(POS_VERSION)) begin
			if (item_s1.data_byte != MAGIC[cnt_q[2:0]]) begin
				hdr_ok_d = 1'b0;
			end
		end else if (cnt_q == 16'(POS_VERSION)) begin
			if (item_s1.data_byte != VER_ONE && item_s1.data_byte != VER_TWO) begin
				hdr_ok_d = 1'b0;
			end
			fmt_two_d = (item_s1.data_byte == VER_TWO);
		end else if (cnt_q == 16'(POS_PAD)) begin
			if (item_s1.data_byte != 8'd0) begin
				hdr_ok_d = 1'b0;
			end
		end else if (cnt_q < 16'(POS_TIME_END)) begin
			time_d[cnt_q[2:0]] = item_s1.data_byte;
		end else if (cnt_q >= 16'(POS_KIND) && cnt_q < 16'(POS_KIND_END)) begin
			kind_d[cnt_q[1:0]] = item_s1.data_byte;
		end else if (cnt_q >= 16'(POS_LEN) && cnt_q < 16'(POS_LEN_END)) begin
			len_d[len_off[3:2]][len_off[1:0]] = item_s1.data_byte;
		end

		// The newest four bytes are held back from the CRC.
		crc_d = (cnt_q >= 16'(POS_CRC_START)) ? crc32c_byte(crc_q, win_q[7:0]) : crc_q;
		win_d = {item_s1.data_byte, win_q[31:8]};
		cnt_d = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	end

	// ------------------------------------------------------------------------
	// Checks on the snapshot.
	// ------------------------------------------------------------------------
	assign arch_len = fmt_two_s2 ? len_s2[3] : 32'd0;
	assign hdr4     = fmt_two_s2 ? 7'(V2_HEADER_BYTES + TRAIL_BYTES)
	                             : 7'(V1_HEADER_BYTES + TRAIL_BYTES);

	assign chk = hdr_ok_s2
		&& n_s2 >= 17'(V1_HEADER_BYTES + TRAIL_BYTES)
		&& n_s2 <= {1'b0, record_limit_q}
		&& n_s2 == {1'b0, decl_s2}
		&& n_s2 >= {10'd0, hdr4}
		&& len_s2[0] <= {16'd0, field_limit_q}
		&& len_s2[1] <= {16'd0, field_limit_q}
		&& len_s2[2] <= {24'd0, version_limit_q}
		&& kind_s2 >= KIND_MIN && kind_s2 <= KIND_MAX
		&& arch_len <= {24'd0, arch_limit_q}
		&& !(fmt_two_s2 && arch_len == 32'd0)
		&& time_s2 != 64'd0 && !time_s2[63]
		&& win_s2 == ~crc_s2;

	assign total  = {1'b0, sum_a_s3} + {1'b0, sum_b_s3} + {27'd0, hdr4_s3};
	assign rec_ok = chk_s3 && total == {18'd0, decl_s3};

	// ------------------------------------------------------------------------
	// Control and state registers.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_limit_q   <= FIELD_LIMIT_RST;
			version_limit_q <= VERSION_LIMIT_RST;
			arch_limit_q    <= ARCH_LIMIT_RST;
			record_limit_q  <= RECORD_LIMIT_RST;
			cnt_q           <= '0;
			crc_q           <= CRC_INIT;
			win_q           <= '0;
			hdr_ok_q        <= 1'b1;
			fmt_two_q       <= 1'b0;
			time_q          <= '0;
			kind_q          <= '0;
			len_q           <= '0;
			vld_s1          <= 1'b0;
			vld_s2          <= 1'b0;
			vld_s3          <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIELD_LIMIT:   field_limit_q   <= cfg_data;
					REG_VERSION_LIMIT: version_limit_q <= cfg_data[7:0];
					REG_ARCH_LIMIT:    arch_limit_q    <= cfg_data[7:0];
					REG_RECORD_LIMIT:  record_limit_q  <= cfg_data;
					default: ;
				endcase
			end

			if (rec_ready) begin
				vld_s1 <= rec_valid;
			end

			if (s1_adv) begin
				if (item_s1.last_byte) begin
					cnt_q     <= '0;
					crc_q     <= CRC_INIT;
					win_q     <= '0;
					hdr_ok_q  <= 1'b1;
					fmt_two_q <= 1'b0;
					time_q    <= '0;
					kind_q    <= '0;
					len_q     <= '0;
				end else begin
					cnt_q     <= cnt_d;
					crc_q     <= crc_d;
					win_q     <= win_d;
					hdr_ok_q  <= hdr_ok_d;
					fmt_two_q <= fmt_two_d;
					time_q    <= time_d;
					kind_q    <= kind_d;
					len_q     <= len_d;
				end
			end

			if (s2_free) begin
				vld_s2 <= s1_adv && item_s1.last_byte;
			end
			if (s3_free) begin
				vld_s3 <= vld_s2;
			end
			if (out_free) begin
				res_valid_q <= vld_s3;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			item_s1 <= rec_item;
		end

		if (s2_free && s1_adv && item_s1.last_byte) begin
			n_s2       <= {1'b0, cnt_q} + 17'd1;
			decl_s2    <= item_s1.declared_size;
			hdr_ok_s2  <= hdr_ok_d;
			fmt_two_s2 <= fmt_two_d;
			time_s2    <= time_d;
			kind_s2    <= kind_d;
			len_s2     <= len_d;
			crc_s2     <= crc_d;
			win_s2     <= win_d;
		end

		if (s3_free && vld_s2) begin
			chk_s3   <= chk;
			sum_a_s3 <= {1'b0, len_s2[0]} + {1'b0, len_s2[1]};
			sum_b_s3 <= {1'b0, len_s2[2]} + {1'b0, arch_len};
			hdr4_s3  <= hdr4;
			decl_s3  <= decl_s2;
			time_s3  <= time_s2[62:0];
		end

		if (out_free && vld_s3) begin
			res_item_q.valid_res <= rec_ok;
			res_item_q.timestamp <= rec_ok ? time_s3 : 63'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	`CRV_ASSERT(a_reject_zero_time, res_valid && !res_item.valid_res |-> res_item.timestamp == 63'd0, "rejected record carries a timestamp")
	`CRV_ASSERT(a_stall_on_last, !rec_ready |-> vld_s1 && item_s1.last_byte, "input stalled without a waiting last byte")
	`CRV_ASSERT(a_clear_after_last, s1_adv && item_s1.last_byte |=> cnt_q == 16'd0 && crc_q == CRC_INIT && hdr_ok_q, "record state not cleared after last byte")
	`CRV_ASSERT(a_count_moves, s1_adv && !item_s1.last_byte |=> cnt_q >= $past(cnt_q) && cnt_q != 16'd0, "byte count went backward within a record")
	`CRV_ASSERT_ALWAYS(a_count_idle, !s1_adv |=> cnt_q == $past(cnt_q) || !arst_n || $past(!arst_n), "byte count changed without an item")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Crash record validator testbench
// Streams crash records through the block, both well formed and damaged, under
// several limit settings and idle patterns. A scoreboard works out the verdict
// of each record byte by byte and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
	import crv_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned RANDOM_BYTES  = 400;
	localparam int unsigned MIN_ROUNDS    = 4;

	typedef enum int {
		FLAW_NONE,
		FLAW_MAGIC,
		FLAW_VERSION,
		FLAW_PAD,
		FLAW_TIME_ZERO,
		FLAW_TIME_HIGH,
		FLAW_KIND,
		FLAW_MSG_LEN,
		FLAW_VER_LEN,
		FLAW_ARCH_LEN,
		FLAW_SIZE,
		FLAW_CRC,
		FLAW_SHORT,
		FLAW_EXTRA
	} record_flaw_e;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	class record_verdict_board;
		logic [15:0] field_lim;
		logic [7:0]  version_lim;
		logic [7:0]  arch_lim;
		logic [15:0] size_lim;

		logic [15:0] byte_pos;
		logic [31:0] crc_acc;
		logic [31:0] tail_bytes;
		bit          header_good;
		bit          is_v2;
		logic [63:0] stamp;
		logic [31:0] kind;
		logic [31:0] lens[4];

		res_item_t   verdicts_due[$];
		int unsigned errors;

		function new();
			field_lim   = FIELD_LIMIT_RST;
			version_lim = VERSION_LIMIT_RST;
			arch_lim    = ARCH_LIMIT_RST;
			size_lim    = RECORD_LIMIT_RST;
			errors      = 0;
			restart();
		endfunction

		static function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] d);
			bit fb;
			for (int k = 0; k < 8; k++) begin
				fb  = acc[0] ^ d[k];
				acc = acc >> 1;
				if (fb)
					acc = acc ^ CRC_POLY;
			end
			return acc;
		endfunction

		function void restart();
			byte_pos    = '0;
			crc_acc     = CRC_INIT;
			tail_bytes  = '0;
			header_good = 1'b1;
			is_v2       = 1'b0;
			stamp       = '0;
			kind        = '0;
			foreach (lens[i])
				lens[i] = '0;
		endfunction

		function void write_reg(cfg_reg_e_t idx, logic [15:0] val);
			case (idx)
			REG_FIELD_LIMIT:   field_lim = val;
			REG_VERSION_LIMIT: version_lim = val[7:0];
			REG_ARCH_LIMIT:    arch_lim = val[7:0];
			REG_RECORD_LIMIT:  size_lim = val;
			default: ;
			endcase
		endfunction

		function void take_byte(rec_item_t it);
			int unsigned     p;
			logic [7:0]      b;
			longint unsigned n;
			longint unsigned hdr;
			longint unsigned arch;
			longint unsigned total;
			bit              ok;
			res_item_t       v;
			p = byte_pos;
			b = it.data_byte;
			if (p < POS_VERSION) begin
				if (b != MAGIC[p])
					header_good = 1'b0;
			end else if (p == POS_VERSION) begin
				if (b != VER_ONE && b != VER_TWO)
					header_good = 1'b0;
				is_v2 = (b == VER_TWO);
			end else if (p == POS_PAD) begin
				if (b != 8'd0)
					header_good = 1'b0;
			end else if (p < POS_TIME_END) begin
				stamp[8*(p-POS_TIME) +: 8] = b;
			end else if (p >= POS_KIND && p < POS_KIND_END) begin
				kind[8*(p-POS_KIND) +: 8] = b;
			end else if (p >= POS_LEN && p < POS_LEN_END) begin
				lens[(p-POS_LEN)/4][8*((p-POS_LEN)%4) +: 8] = b;
			end
			// The newest four bytes stay in the window and reach the CRC later.
			if (p >= POS_CRC_START)
				crc_acc = crc_step(crc_acc, tail_bytes[7:0]);
			tail_bytes = {b, tail_bytes[31:8]};
			if (byte_pos != 16'hFFFF)
				byte_pos++;
			if (!it.last_byte)
				return;

			n     = p + 1;
			hdr   = is_v2 ? V2_HEADER_BYTES : V1_HEADER_BYTES;
			arch  = is_v2 ? lens[3] : 0;
			total = hdr + lens[0] + lens[1] + lens[2] + arch + TRAIL_BYTES;
			ok = header_good
				&& n >= V1_HEADER_BYTES + TRAIL_BYTES
				&& n <= size_lim
				&& n == it.declared_size
				&& n >= hdr + TRAIL_BYTES
				&& lens[0] <= field_lim
				&& lens[1] <= field_lim
				&& lens[2] <= version_lim
				&& kind >= KIND_MIN && kind <= KIND_MAX
				&& arch <= arch_lim
				&& !(is_v2 && arch == 0)
				&& it.declared_size == total
				&& stamp != 0 && !stamp[63]
				&& tail_bytes == ~crc_acc;
			v.valid_res = ok;
			v.timestamp = ok ? stamp[62:0] : '0;
			verdicts_due.push_back(v);
			restart();
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void compare(res_item_t got);
			res_item_t want;
			if (verdicts_due.size() == 0) begin
				note_error($sformatf("result with no record pending: valid_res=%0b timestamp=%0h",
					got.valid_res, got.timestamp));
				return;
			end
			want = verdicts_due.pop_front();
			if (got.valid_res !== want.valid_res)
				note_error($sformatf("valid_res expected %0b, got %0b", want.valid_res,
					got.valid_res));
			if (got.timestamp !== want.timestamp)
				note_error($sformatf("timestamp expected %0h, got %0h", want.timestamp,
					got.timestamp));
		endfunction

		function int unsigned pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   rec_valid = 1'b0;
	logic                   rec_ready;
	rec_item_t              rec_item = '0;
	logic                   res_valid;
	logic                   res_ready = 1'b0;
	res_item_t              res_item;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	record_verdict_board board = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  rec_bytes[$];
	logic [15:0] rec_size_decl;

	crash_record_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_item  (rec_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		res_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready)
				board.compare(res_item);
			if (rec_valid && rec_ready)
				board.take_byte(rec_item);
			if ((res_valid && res_ready) || (rec_valid && rec_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [63:0] fresh_stamp();
		return {1'b0, 31'($urandom), 32'($urandom)};
	endfunction

	// Lays out one record in rec_bytes with its CRC; field flaws go in before the CRC, size and CRC flaws after it.
	function automatic void build_record(input record_flaw_e flaw, input bit v2, input bit bare,
		input logic [63:0] stamp, input logic [31:0] kind);
		logic [31:0] lens[4];
		logic [31:0] crc;
		logic [7:0]  b;
		bit          two;
		int unsigned text;
		int unsigned cut;
		int unsigned msg_cap;
		int unsigned ver_cap;
		int unsigned arch_cap;
		two      = v2 || flaw == FLAW_ARCH_LEN;
		msg_cap  = board.field_lim < 12 ? board.field_lim : 12;
		ver_cap  = board.version_lim < 8 ? board.version_lim : 8;
		arch_cap = board.arch_lim < 6 ? board.arch_lim : 6;
		for (int i = 0; i < 2; i++)
			lens[i] = (bare || $urandom_range(1)) ? 0 : $urandom_range(0, msg_cap);
		lens[2] = (bare || $urandom_range(1)) ? 0 : $urandom_range(0, ver_cap);
		lens[3] = !two ? 0 : (bare ? 1 : $urandom_range(1, arch_cap));

		case (flaw)
		FLAW_TIME_ZERO: stamp = '0;
		FLAW_TIME_HIGH: stamp[63] = 1'b1;
		FLAW_KIND: begin
			case ($urandom_range(2))
			0: kind = KIND_MIN - 1;
			1: kind = KIND_MAX + 1;
			default: kind = $urandom;
			endcase
		end
		FLAW_MSG_LEN: begin
			if (board.field_lim < 64)
				lens[0] = board.field_lim + 1;
		end
		FLAW_VER_LEN: lens[2] = board.version_lim + 1;
		FLAW_ARCH_LEN: lens[3] = $urandom_range(1) ? 0 : board.arch_lim + 1;
		default: ;
		endcase

		rec_bytes.delete();
		for (int i = 0; i < 6; i++)
			rec_bytes.push_back(MAGIC[i]);
		rec_bytes.push_back(two ? VER_TWO : VER_ONE);
		rec_bytes.push_back(8'd0);
		for (int i = 0; i < 8; i++)
			rec_bytes.push_back(stamp[8*i +: 8]);
		for (int i = 0; i < 8; i++)
			rec_bytes.push_back(8'($urandom));
		for (int i = 0; i < 4; i++)
			rec_bytes.push_back(kind[8*i +: 8]);
		for (int k = 0; k < (two ? 4 : 3); k++) begin
			for (int i = 0; i < 4; i++)
				rec_bytes.push_back(lens[k][8*i +: 8]);
		end
		text = lens[0] + lens[1] + lens[2] + lens[3];
		for (int i = 0; i < text; i++)
			rec_bytes.push_back(8'($urandom));

		case (flaw)
		FLAW_MAGIC: rec_bytes[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
		FLAW_VERSION: begin
			b = 8'($urandom);
			if (b == VER_ONE || b == VER_TWO)
				b ^= 8'h80;
			rec_bytes[POS_VERSION] = b;
		end
		FLAW_PAD: rec_bytes[POS_PAD] = 8'($urandom_range(1, 255));
		default: ;
		endcase

		crc = CRC_INIT;
		foreach (rec_bytes[i])
			crc = record_verdict_board::crc_step(crc, rec_bytes[i]);
		crc = ~crc;
		for (int i = 0; i < 4; i++)
			rec_bytes.push_back(crc[8*i +: 8]);
		rec_size_decl = 16'(rec_bytes.size());

		case (flaw)
		FLAW_CRC: begin
			rec_bytes[rec_bytes.size() - 1 - $urandom_range(0, 3)] ^=
				8'(1 << $urandom_range(0, 7));
		end
		FLAW_SIZE: begin
			if ($urandom_range(1))
				rec_size_decl = $urandom_range(1) ? 16'(rec_size_decl + 1)
					: 16'(rec_size_decl - 1);
			else
				rec_size_decl = 16'($urandom);
		end
		FLAW_SHORT: begin
			cut = $urandom_range(1, rec_bytes.size() - 1);
			while (rec_bytes.size() > cut)
				void'(rec_bytes.pop_back());
			if ($urandom_range(1))
				rec_size_decl = 16'(cut);
		end
		FLAW_EXTRA: begin
			rec_bytes.push_back(8'($urandom));
			if ($urandom_range(1))
				rec_size_decl = 16'(rec_bytes.size());
		end
		default: ;
		endcase
	endfunction

	// Short runs of random bytes, half of them opening with the magic text.
	function automatic void build_noise();
		int unsigned len;
		bit          lead;
		len  = $urandom_range(1, 16);
		lead = 1'($urandom_range(1));
		rec_bytes.delete();
		for (int i = 0; i < len; i++)
			rec_bytes.push_back((lead && i < 6) ? MAGIC[i] : 8'($urandom));
		rec_size_decl = $urandom_range(1) ? 16'(len) : 16'($urandom);
	endfunction

	task automatic push_byte(input rec_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			rec_valid <= 1'b0;
			@(posedge clk);
		end
		rec_valid <= 1'b1;
		rec_item  <= it;
		@(posedge clk);
		while (!rec_ready)
			@(posedge clk);
	endtask

	task automatic send_record();
		rec_item_t it;
		for (int i = 0; i < rec_bytes.size(); i++) begin
			it.data_byte     = rec_bytes[i];
			it.last_byte     = (i == rec_bytes.size() - 1);
			it.declared_size = rec_size_decl;
			push_byte(it);
		end
	endtask

	// Holds the record channel until every verdict has come back.
	task automatic drain();
		rec_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(input logic [15:0] f, input logic [7:0] v, input logic [7:0] a,
		input logic [15:0] r);
		cfg_reg_e_t  regs[4];
		logic [15:0] vals[4];
		regs = '{REG_FIELD_LIMIT, REG_VERSION_LIMIT, REG_ARCH_LIMIT, REG_RECORD_LIMIT};
		vals = '{f, {8'd0, v}, {8'd0, a}, r};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			board.write_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_e m);
		case (m)
		IDLE_SENDER: begin
			send_idle_pct  = 62;
			recv_stall_pct = 0;
		end
		IDLE_RECEIVER: begin
			send_idle_pct  = 0;
			recv_stall_pct = 62;
		end
		IDLE_BOTH: begin
			send_idle_pct  = 26;
			recv_stall_pct = 26;
		end
		default: begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		endcase
	endtask

	initial begin
		int unsigned round_no;
		int unsigned random_bytes;
		round_no     = 0;
		random_bytes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records under the reset limits.
		set_idling(IDLE_NONE);
		build_record(FLAW_NONE, 1'b0, 1'b1, 64'd1, KIND_MIN);
		send_record();
		build_record(FLAW_NONE, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, KIND_MAX);
		send_record();
		for (int f = FLAW_MAGIC; f <= FLAW_EXTRA; f++) begin
			build_record(record_flaw_e'(f), 1'($urandom_range(1)), 1'b0, fresh_stamp(),
				$urandom_range(KIND_MIN, KIND_MAX));
			send_record();
		end
		rec_bytes.delete();
		rec_bytes.push_back(8'hFF);
		rec_size_decl = 16'hFFFF;
		send_record();
		drain();

		while (random_bytes < RANDOM_BYTES || round_no < MIN_ROUNDS) begin
			case (round_no % 4)
			0: set_limits(16'd0, 8'd0, 8'd1, 16'd48);
			1: set_limits(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
			2: set_limits(16'($urandom_range(0, 40)), 8'($urandom_range(0, 20)),
				8'($urandom_range(1, 12)), 16'($urandom_range(48, 700)));
			default: set_limits(FIELD_LIMIT_RST, VERSION_LIMIT_RST, ARCH_LIMIT_RST,
				RECORD_LIMIT_RST);
			endcase
			set_idling(idle_mode_e'((round_no + round_no / 4) % 4));
			repeat (3) begin
				if ($urandom_range(9) < 3)
					build_noise();
				else
					build_record($urandom_range(1) ? FLAW_NONE :
						record_flaw_e'($urandom_range(FLAW_MAGIC, FLAW_EXTRA)),
						1'($urandom_range(1)), 1'b0, fresh_stamp(),
						$urandom_range(KIND_MIN, KIND_MAX));
				send_record();
				random_bytes += rec_bytes.size();
				if ($urandom_range(9) == 0)
					drain();
			end
			drain();
			round_no++;
		end

		if (board.errors == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/crv_pkg.sv
rtl/core/crash_record_validator.sv
tb/testbench.sv
